[rtl/spq_pkg.sv]
// sorted priority queue package: transaction kind codes and cell control struct
// no dependencies
package spq_pkg;

    typedef enum logic {
        KIND_JOIN  = 1'b0,
        KIND_LEAVE = 1'b1
    } spq_kind_t;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic shift_in;   // insert a new entry at its sorted place
        logic shift_out;  // drop the head, every cell but the tail pulls from its right neighbor
    } spq_ctrl_t;

endpackage

[rtl/spq_if.sv]
// valid/ready channel interfaces for the sorted priority queue
// no dependencies

interface spq_item_if #(
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 16
);
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [PRIORITY_BITS-1:0] item_priority;
    logic [TAG_BITS-1:0]      item_tag;

    modport source (output valid, output kind, output item_priority, output item_tag,
                    input ready);
    modport sink (input valid, input kind, input item_priority, input item_tag,
                  output ready);
endinterface

interface spq_result_if #(
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 16,
    parameter int COUNT_BITS    = 5
);
    logic                     valid;
    logic                     ready;
    logic [TAG_BITS-1:0]      removed_tag;
    logic                     removed_valid;
    logic [TAG_BITS-1:0]      front_tag;
    logic [PRIORITY_BITS-1:0] front_priority;
    logic                     is_empty;
    logic                     join_dropped;
    logic [COUNT_BITS-1:0]    occupancy;

    modport source (output valid, output removed_tag, output removed_valid,
                    output front_tag, output front_priority, output is_empty,
                    output join_dropped, output occupancy, input ready);
    modport sink (input valid, input removed_tag, input removed_valid,
                  input front_tag, input front_priority, input is_empty,
                  input join_dropped, input occupancy, output ready);
endinterface

[rtl/spq_cell.sv]
// one slot of the sorted chain: holds a priority and a tag
// depends on spq_pkg
module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 16
) (
    input  logic                     clk,
    input  spq_ctrl_t                ctrl,
    input  logic                     occupied,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic [TAG_BITS-1:0]      new_tag,
    input  logic                     left_less,
    input  logic [PRIORITY_BITS-1:0] left_prio,
    input  logic [TAG_BITS-1:0]      left_tag,
    input  logic [PRIORITY_BITS-1:0] right_prio,
    input  logic [TAG_BITS-1:0]      right_tag,
    output logic                     less,
    output logic [PRIORITY_BITS-1:0] prio,
    output logic [TAG_BITS-1:0]      tag,
    output logic [PRIORITY_BITS-1:0] prio_next,
    output logic [TAG_BITS-1:0]      tag_next
);

    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [TAG_BITS-1:0]      tag_reg;

    // entry stays ahead of the newcomer only when strictly smaller
    assign less = occupied && (prio_reg < new_prio);
    assign prio = prio_reg;
    assign tag  = tag_reg;

    always_comb
    begin
        prio_next = prio_reg;
        tag_next  = tag_reg;
        if (ctrl.shift_out)
        begin
            prio_next = right_prio;
            tag_next  = right_tag;
        end
        else if (ctrl.shift_in && !less)
        begin
            if (left_less)
            begin
                prio_next = new_prio;
                tag_next  = new_tag;
            end
            else
            begin
                prio_next = left_prio;
                tag_next  = left_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

endmodule

[rtl/sorted_priority_queue.sv]
// sorted priority queue top level: chain of spq_cell slots, entry count, result register
// depends on spq_pkg, spq_if (spq_item_if, spq_result_if) and spq_cell
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    kind, item_priority, item_tag
//   result   out  valid/ready    removed_tag, removed_valid, front_tag, front_priority,
//                                is_empty, join_dropped, occupancy
//
// for every item transaction all cells compare against the new priority
// at once and shift in the same edge, so one comparator per cell sets the pace
// the result of a transaction appears in the result register in the cycle after acceptance
// reset clears the entry count and the result valid; slot contents are left as they are
// item.ready is high while the result register is empty or being drained, so a new
// item is taken in the same cycle that the previous result leaves
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    spq_item_if.sink     item,
    spq_result_if.source result
);

    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // entry count
    logic [COUNT_BITS-1:0]    count_reg;
    logic [COUNT_BITS-1:0]    count_next;

    // result register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [TAG_BITS-1:0]      removed_tag_reg;
    logic                     removed_valid_reg;
    logic [TAG_BITS-1:0]      front_tag_reg;
    logic [PRIORITY_BITS-1:0] front_prio_reg;
    logic                     is_empty_reg;
    logic                     dropped_reg;
    logic [COUNT_BITS-1:0]    occ_reg;

    logic                     accept;
    logic                     is_join;
    logic                     full;
    logic                     empty;
    spq_ctrl_t                ctrl;

    // per-cell wires
    logic                     cell_less [QUEUE_DEPTH];
    logic                     cell_occ  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      cell_tag  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_pnext [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      cell_tnext [QUEUE_DEPTH];

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign is_join    = (item.kind == KIND_JOIN);
    assign full       = (count_reg == COUNT_BITS'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);

    // a join to a full queue and a leave from an empty queue leave the chain alone
    assign ctrl.shift_in  = accept && is_join && !full;
    assign ctrl.shift_out = accept && !is_join && !empty;

    // the chain of slots, head at index 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                     left_less;
        logic [PRIORITY_BITS-1:0] left_prio;
        logic [TAG_BITS-1:0]      left_tag;
        logic [PRIORITY_BITS-1:0] right_prio;
        logic [TAG_BITS-1:0]      right_tag;

        assign cell_occ[i] = (COUNT_BITS'(i) < count_reg);

        if (i == 0)
        begin : g_head
            // nothing sits ahead of the head, so a non-smaller head takes the newcomer
            assign left_less = 1'b1;
            assign left_prio = item.item_priority;
            assign left_tag  = item.item_tag;
        end
        else
        begin : g_body
            assign left_less = cell_less[i-1];
            assign left_prio = cell_prio[i-1];
            assign left_tag  = cell_tag[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            // last slot becomes unused after a leave
            assign right_prio = cell_prio[i];
            assign right_tag  = cell_tag[i];
        end
        else
        begin : g_inner
            assign right_prio = cell_prio[i+1];
            assign right_tag  = cell_tag[i+1];
        end

        spq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .TAG_BITS      (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (cell_occ[i]),
            .new_prio   (item.item_priority),
            .new_tag    (item.item_tag),
            .left_less  (left_less),
            .left_prio  (left_prio),
            .left_tag   (left_tag),
            .right_prio (right_prio),
            .right_tag  (right_tag),
            .less       (cell_less[i]),
            .prio       (cell_prio[i]),
            .tag        (cell_tag[i]),
            .prio_next  (cell_pnext[i]),
            .tag_next   (cell_tnext[i])
        );
    end

    // entry count and result valid
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.shift_in)
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        else if (ctrl.shift_out)
        begin
            count_next = count_reg - COUNT_BITS'(1);
        end

        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, built from the head's next value and the next count
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_tag_reg   <= ctrl.shift_out ? cell_tag[0] : '0;
            removed_valid_reg <= ctrl.shift_out;
            front_tag_reg     <= (count_next == '0) ? '0 : cell_tnext[0];
            front_prio_reg    <= (count_next == '0) ? '0 : cell_pnext[0];
            is_empty_reg      <= (count_next == '0);
            dropped_reg       <= is_join && full;
            occ_reg           <= count_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.removed_tag    = removed_tag_reg;
    assign result.removed_valid  = removed_valid_reg;
    assign result.front_tag      = front_tag_reg;
    assign result.front_priority = front_prio_reg;
    assign result.is_empty       = is_empty_reg;
    assign result.join_dropped   = dropped_reg;
    assign result.occupancy      = occ_reg;

    // count never goes past the number of slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // a dropped join is reported only with a full queue
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.join_dropped) |->
            (result.occupancy == COUNT_BITS'(QUEUE_DEPTH)))
        else $error("join dropped while queue not full");

    // a removal always takes exactly one entry away
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift_out |=> (count_reg == $past(count_reg) - COUNT_BITS'(1)))
        else $error("leave did not decrement count");

    // a held result stays put while the sink stalls
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(occ_reg)))
        else $error("stalled transaction changed");

endmodule
